[design/fct_pkg.sv]
package fct_pkg;

    localparam int unsigned CFG_W  = 13;
    localparam int unsigned LINK_W = 16;

    localparam logic [CFG_W-1:0] ENTRY_COUNT_RESET = 13'd4096;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_SET   = 2'd1;
    localparam logic [1:0] MODE_ALLOC = 2'd2;
    localparam logic [1:0] MODE_FREE  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_LIMIT = 2'd3;

    localparam logic [LINK_W-1:0] LINK_FREE    = 16'h0000;
    localparam logic [LINK_W-1:0] LINK_EOC     = 16'hFFFF;
    localparam logic [LINK_W-1:0] LINK_EOC_MIN = 16'hFFF8;
    localparam logic [LINK_W-1:0] FIRST_DATA   = 16'd2;

    typedef struct packed {
        logic rd;
        logic wr;
    } mem_cmd_t;

    typedef enum logic [7:0] {
        S_CLEAR     = 8'b0000_0001,
        S_IDLE      = 8'b0000_0010,
        S_EXEC      = 8'b0000_0100,
        S_RD_WAIT   = 8'b0000_1000,
        S_ALLOC_RD  = 8'b0001_0000,
        S_ALLOC_CHK = 8'b0010_0000,
        S_FREE_CHK  = 8'b0100_0000,
        S_FREE_WR   = 8'b1000_0000
    } state_t;

endpackage

[design/fct_ram.sv]
module fct_ram #(
    parameter int unsigned TABLE_ENTRIES = 4096
) (
    input  logic                             clk,
    input  fct_pkg::mem_cmd_t                cmd,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] addr,
    input  logic [15:0]                      wdata,
    output logic [15:0]                      rdata
);
    import fct_pkg::*;

    logic [LINK_W-1:0] mem [TABLE_ENTRIES];
    logic [LINK_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/fct_ctrl.sv]
module fct_ctrl #(
    parameter int unsigned TABLE_ENTRIES = 4096,
    localparam int unsigned AW = $clog2(TABLE_ENTRIES),
    localparam int unsigned NW = ($clog2(TABLE_ENTRIES + 1) > 13) ?
                                 $clog2(TABLE_ENTRIES + 1) : 13,
    localparam int unsigned CW = (NW > 16) ? NW : 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        mode,
    input  logic [15:0]       cluster,
    input  logic [15:0]       link_value,
    input  logic [CW-1:0]     active_count,
    output fct_pkg::mem_cmd_t mem_cmd,
    output logic [AW-1:0]     mem_addr,
    output logic [15:0]       mem_wdata,
    input  logic [15:0]       mem_rdata,
    output logic              done,
    output logic [15:0]       result_cluster,
    output logic [1:0]        status
);
    import fct_pkg::*;

    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [1:0]        mode_reg, mode_next;
    logic [LINK_W-1:0] cl_reg, cl_next;
    logic [LINK_W-1:0] link_reg, link_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic [CW-1:0]     steps_reg, steps_next;
    logic              done_reg, done_next;
    logic [LINK_W-1:0] result_reg, result_next;
    logic [1:0]        status_reg, status_next;
    logic              cl_in_range;
    logic              ptr_in_range;
    logic              cl_in_chain;

    assign cl_in_range  = CW'(cl_reg) < active_count;
    assign ptr_in_range = ptr_reg < active_count;
    assign cl_in_chain  = (cl_reg >= FIRST_DATA) && (cl_reg < LINK_EOC_MIN);

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        mode_next   = mode_reg;
        cl_next     = cl_reg;
        link_next   = link_reg;
        ptr_next    = ptr_reg;
        steps_next  = steps_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        status_next = status_reg;
        mem_cmd     = '0;
        mem_addr    = '0;
        mem_wdata   = LINK_FREE;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_cmd.wr = 1'b1;
                mem_addr   = clr_reg;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next  = mode;
                    cl_next    = cluster;
                    link_next  = link_value;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                result_next = LINK_FREE;
                status_next = ST_OK;
                case (mode_reg)
                    MODE_READ:
                    begin
                        if (cl_in_range)
                        begin
                            mem_cmd.rd = 1'b1;
                            mem_addr   = cl_reg[AW-1:0];
                            state_next = S_RD_WAIT;
                        end
                        else
                        begin
                            status_next = ST_RANGE;
                            done_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                    end
                    MODE_SET:
                    begin
                        if (cl_in_range)
                        begin
                            mem_cmd.wr = 1'b1;
                            mem_addr   = cl_reg[AW-1:0];
                            mem_wdata  = link_reg;
                        end
                        else
                        begin
                            status_next = ST_RANGE;
                        end
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    MODE_ALLOC:
                    begin
                        ptr_next   = CW'(FIRST_DATA);
                        state_next = S_ALLOC_RD;
                    end
                    default:
                    begin
                        steps_next = '0;
                        state_next = S_FREE_CHK;
                    end
                endcase
            end
            S_RD_WAIT:
            begin
                result_next = mem_rdata;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            S_ALLOC_RD:
            begin
                if (ptr_in_range)
                begin
                    mem_cmd.rd = 1'b1;
                    mem_addr   = ptr_reg[AW-1:0];
                    state_next = S_ALLOC_CHK;
                end
                else
                begin
                    status_next = ST_FULL;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_ALLOC_CHK:
            begin
                if (mem_rdata == LINK_FREE)
                begin
                    mem_cmd.wr  = 1'b1;
                    mem_addr    = ptr_reg[AW-1:0];
                    mem_wdata   = LINK_EOC;
                    result_next = ptr_reg[LINK_W-1:0];
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = S_ALLOC_RD;
                end
            end
            S_FREE_CHK:
            begin
                if (!cl_in_chain)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (steps_reg >= active_count)
                begin
                    status_next = ST_LIMIT;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (!cl_in_range)
                begin
                    status_next = ST_RANGE;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    mem_cmd.rd = 1'b1;
                    mem_addr   = cl_reg[AW-1:0];
                    state_next = S_FREE_WR;
                end
            end
            S_FREE_WR:
            begin
                mem_cmd.wr = 1'b1;
                mem_addr   = cl_reg[AW-1:0];
                mem_wdata  = LINK_FREE;
                cl_next    = mem_rdata;
                steps_next = steps_reg + 1'b1;
                state_next = S_FREE_CHK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        cl_reg     <= cl_next;
        link_reg   <= link_next;
        ptr_reg    <= ptr_next;
        steps_reg  <= steps_next;
        result_reg <= result_next;
        status_reg <= status_next;
    end

    assign busy           = state_reg != S_IDLE;
    assign done           = done_reg;
    assign result_cluster = result_reg;
    assign status         = status_reg;

endmodule

[design/fat_cluster_chain_table.sv]
// FAT16 cluster link table with read, set, allocate and free-chain operations.
//
// Command channel: an item (mode, cluster, link_value) is taken on a rising
// edge with start high and busy low. busy stays high until the item is done.
// Result channel: done is high for exactly one cycle with result_cluster and
// status; the receiver cannot stall it, so results must be taken as shown.
// Config channel: cfg_data (entry_count) is written on cfg_valid && cfg_ready;
// cfg_ready is always high. Write it only while the block is idle.
//
// Steps after accept: read takes EXEC and RD_WAIT, set takes EXEC only,
// allocate takes EXEC then ALLOC_RD and ALLOC_CHK per entry scanned (from
// cluster 2, the free one included) and a last ALLOC_RD when the table is
// full, free takes EXEC then FREE_CHK and FREE_WR per entry freed and a last
// FREE_CHK. A new item can be taken while done is high. One single-port table
// RAM is shared by every step, one access per cycle, so each table visit is a
// read step followed by a check or write-back step.
// Reset: the table is cleared to free by a pass over all TABLE_ENTRIES
// entries, one entry per cycle, with busy high; entry_count resets to 4096.
module fat_cluster_chain_table #(
    parameter int unsigned TABLE_ENTRIES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [15:0] cluster,
    input  logic [15:0] link_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data,
    output logic        done,
    output logic [15:0] result_cluster,
    output logic [1:0]  status
);
    import fct_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_ENTRIES);
    localparam int unsigned NW = ($clog2(TABLE_ENTRIES + 1) > 13) ?
                                 $clog2(TABLE_ENTRIES + 1) : 13;
    localparam int unsigned CW = (NW > 16) ? NW : 16;

    logic [CFG_W-1:0]  entry_count_reg;
    logic [CW-1:0]     active_count;
    mem_cmd_t          mem_cmd;
    logic [AW-1:0]     mem_addr;
    logic [LINK_W-1:0] mem_wdata;
    logic [LINK_W-1:0] mem_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= ENTRY_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            entry_count_reg <= cfg_data;
        end
    end

    // clamp to the table size
    assign active_count = (CW'(entry_count_reg) > CW'(TABLE_ENTRIES)) ?
                          CW'(TABLE_ENTRIES) : CW'(entry_count_reg);

    fct_ctrl #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .cluster       (cluster),
        .link_value    (link_value),
        .active_count  (active_count),
        .mem_cmd       (mem_cmd),
        .mem_addr      (mem_addr),
        .mem_wdata     (mem_wdata),
        .mem_rdata     (mem_rdata),
        .done          (done),
        .result_cluster(result_cluster),
        .status        (status)
    );

    fct_ram #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_ram (
        .clk  (clk),
        .cmd  (mem_cmd),
        .addr (mem_addr),
        .wdata(mem_wdata),
        .rdata(mem_rdata)
    );

endmodule

[design/fct_checker.sv]
module fct_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [15:0] result_cluster,
    input logic [1:0]  status
);
    import fct_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy low after accepted beat");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without work in progress");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two result beats in a row");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (result_cluster == LINK_FREE))
        else $error("nonzero result with error status");

endmodule

bind fat_cluster_chain_table fct_checker u_fct_checker (.*);

[sim/tb_top.sv]
module tb_top;
    import fct_pkg::*;

    localparam int unsigned TABLE_ENTRIES = 4096;

    typedef struct packed {
        logic [LINK_W-1:0] cl;
        logic [1:0]        st;
    } fat_result_t;

    class fat_scoreboard;
        logic [LINK_W-1:0] links [TABLE_ENTRIES];
        logic [CFG_W-1:0]  entry_count;
        fat_result_t       awaited [$];
        int                errors;

        function new();
            foreach (links[i]) links[i] = LINK_FREE;
            entry_count = ENTRY_COUNT_RESET;
            errors = 0;
        endfunction

        function void set_count(logic [CFG_W-1:0] v);
            entry_count = v;
        endfunction

        function int unsigned live_entries();
            int unsigned n;
            n = 32'(entry_count);
            if (n > TABLE_ENTRIES)
                n = TABLE_ENTRIES;
            return n;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_item(logic [1:0] m, logic [LINK_W-1:0] cl, logic [LINK_W-1:0] val);
            int unsigned n;
            int unsigned cli;
            int unsigned cur;
            int unsigned nxt;
            int unsigned steps;
            int unsigned c;
            fat_result_t r;
            n = live_entries();
            cli = 32'(cl);
            r.cl = LINK_FREE;
            r.st = ST_OK;
            case (m)
                MODE_READ:
                begin
                    if (cli < n)
                        r.cl = links[cli];
                    else
                        r.st = ST_RANGE;
                end
                MODE_SET:
                begin
                    if (cli < n)
                        links[cli] = val;
                    else
                        r.st = ST_RANGE;
                end
                MODE_ALLOC:
                begin
                    r.st = ST_FULL;
                    for (c = 32'(FIRST_DATA); c < n; c++)
                    begin
                        if (links[c] == LINK_FREE)
                        begin
                            links[c] = LINK_EOC;
                            r.cl = c[LINK_W-1:0];
                            r.st = ST_OK;
                            break;
                        end
                    end
                end
                default:
                begin
                    cur = cli;
                    steps = 0;
                    while (cur >= 32'(FIRST_DATA) && cur < 32'(LINK_EOC_MIN))
                    begin
                        if (steps >= n)
                        begin
                            r.st = ST_LIMIT;
                            break;
                        end
                        if (cur >= n)
                        begin
                            r.st = ST_RANGE;
                            break;
                        end
                        nxt = 32'(links[cur]);
                        links[cur] = LINK_FREE;
                        cur = nxt;
                        steps++;
                    end
                end
            endcase
            awaited.push_back(r);
        endfunction

        function void check_result(logic [LINK_W-1:0] rc, logic [1:0] st);
            fat_result_t r;
            if (awaited.size() == 0)
            begin
                $error("result with nothing pending: result_cluster %h status %0d", rc, st);
                errors++;
                return;
            end
            r = awaited.pop_front();
            if (rc !== r.cl)
            begin
                $error("result_cluster: expected %h, actual %h", r.cl, rc);
                errors++;
            end
            if (st !== r.st)
            begin
                $error("status: expected %0d, actual %0d", r.st, st);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        mode = MODE_READ;
    logic [LINK_W-1:0] cluster = '0;
    logic [LINK_W-1:0] link_value = '0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              done;
    logic [LINK_W-1:0] result_cluster;
    logic [1:0]        status;

    fat_scoreboard sb;
    longint        cycles = 0;
    longint        cycle_limit = 8 * TABLE_ENTRIES + 5000;
    int            quiet_run = 0;

    fat_cluster_chain_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mode(mode),
        .cluster(cluster),
        .link_value(link_value),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .done(done),
        .result_cluster(result_cluster),
        .status(status)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > cycle_limit)
        begin
            $display("fat_cluster_chain_table: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_result(result_cluster, status);
    end

    task automatic send_cmd(input logic [1:0] m, input logic [LINK_W-1:0] cl,
                            input logic [LINK_W-1:0] lv);
        int gap;
        if (quiet_run > 0)
        begin
            quiet_run--;
            gap = 0;
        end
        else
        begin
            if ($urandom_range(0, 15) == 0)
                quiet_run = $urandom_range(20, 60);
            gap = $urandom_range(0, 16);
        end
        cycle_limit += longint'(4 * (40 + 2 * sb.live_entries()));
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        mode <= m;
        cluster <= cl;
        link_value <= lv;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_item(m, cl, lv);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0 || busy) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_count(input logic [CFG_W-1:0] v);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_count(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [LINK_W-1:0] pick_cluster();
        int unsigned n;
        int r;
        int v;
        n = sb.live_entries();
        r = $urandom_range(0, 99);
        if (r < 80 && n > 0)
            return LINK_W'($urandom_range(0, n - 1));
        if (r < 90)
        begin
            v = int'(n) + int'($urandom_range(0, 3)) - 1;
            if (v < 0)
                v = 0;
            return v[LINK_W-1:0];
        end
        if (r < 95)
            return LINK_EOC_MIN - 16'd1 + LINK_W'($urandom_range(0, 8));
        return LINK_W'($urandom);
    endfunction

    task automatic run_phase(input logic [CFG_W-1:0] count, input int items);
        int pick;
        int r;
        logic [1:0] m;
        logic [LINK_W-1:0] cl;
        logic [LINK_W-1:0] lv;
        write_count(count);
        repeat (items)
        begin
            pick = $urandom_range(0, 99);
            cl = pick_cluster();
            r = $urandom_range(0, 99);
            if (r < 50)
                lv = pick_cluster();
            else if (r < 70)
                lv = LINK_EOC_MIN + LINK_W'($urandom_range(0, 7));
            else if (r < 85)
                lv = LINK_FREE;
            else
                lv = LINK_W'($urandom);
            if (pick < 28)
                m = MODE_ALLOC;
            else if (pick < 56)
                m = MODE_SET;
            else if (pick < 74)
                m = MODE_READ;
            else if (pick < 94)
                m = MODE_FREE;
            else
            begin
                m = 2'($urandom_range(0, 3));
                cl = LINK_W'($urandom);
                lv = LINK_W'($urandom);
            end
            send_cmd(m, cl, lv);
        end
        wait_idle();
    endtask

    initial
    begin
        logic [CFG_W-1:0] cnt;
        int r;
        sb = new();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        wait_idle();

        send_cmd(MODE_READ, 16'd0, 16'h0000);
        send_cmd(MODE_READ, 16'd4095, 16'hFFFF);
        send_cmd(MODE_READ, 16'd4096, 16'h0000);
        send_cmd(MODE_READ, 16'hFFFF, 16'hFFFF);
        send_cmd(MODE_SET, 16'd4095, LINK_EOC);
        send_cmd(MODE_READ, 16'd4095, 16'h0000);
        send_cmd(MODE_SET, 16'd4096, 16'h1234);
        send_cmd(MODE_SET, 16'hFFFF, 16'hFFFF);
        send_cmd(MODE_ALLOC, 16'd0, 16'h0000);
        send_cmd(MODE_ALLOC, 16'hFFFF, 16'hFFFF);
        send_cmd(MODE_SET, 16'd3, 16'd4);
        send_cmd(MODE_SET, 16'd4, LINK_EOC_MIN);
        send_cmd(MODE_FREE, 16'd2, 16'h0000);
        send_cmd(MODE_FREE, 16'd3, 16'h0000);
        send_cmd(MODE_READ, 16'd3, 16'h0000);
        send_cmd(MODE_FREE, 16'd0, 16'h0000);
        send_cmd(MODE_FREE, 16'd1, 16'h0000);
        send_cmd(MODE_FREE, LINK_EOC_MIN, 16'h0000);
        send_cmd(MODE_FREE, LINK_EOC, 16'h0000);
        send_cmd(MODE_FREE, 16'hFFF7, 16'h0000);
        send_cmd(MODE_FREE, 16'd4096, 16'h0000);
        send_cmd(MODE_SET, 16'd5, 16'd4096);
        send_cmd(MODE_FREE, 16'd5, 16'h0000);
        send_cmd(MODE_SET, 16'd6, 16'h5555);
        send_cmd(MODE_READ, 16'd6, 16'hAAAA);

        run_phase(13'd3, 120);
        run_phase(13'd0, 40);
        run_phase(13'd2, 40);
        run_phase(13'd8191, 150);
        run_phase(13'd4096, 150);
        repeat (6)
        begin
            r = $urandom_range(0, 9);
            if (r < 5)
                cnt = CFG_W'($urandom_range(3, 40));
            else if (r < 8)
                cnt = CFG_W'($urandom_range(41, 600));
            else
                cnt = CFG_W'($urandom_range(3, 8191));
            run_phase(cnt, 170);
        end

        wait_idle();
        repeat (16) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("fat_cluster_chain_table: match");
        else
            $display("fat_cluster_chain_table: mismatch");
        $finish;
    end

endmodule

[fat_cluster_chain_table.f]
design/fct_pkg.sv
design/fct_ram.sv
design/fct_ctrl.sv
design/fat_cluster_chain_table.sv
design/fct_checker.sv
sim/tb_top.sv
